[src/gda_pkg.sv]
package gda_pkg;

    localparam int YEAR_W = 17;
    localparam int DN_W   = 25;

    localparam logic [0:0] REQ_ADD  = 1'b0;
    localparam logic [0:0] REQ_DIFF = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic signed [25:0] DIFF_MAX = 26'sd4194303;
    localparam logic signed [25:0] DIFF_MIN = -26'sd4194304;

    // reciprocal of 25 for the century split, exact for dividends below 43690
    localparam logic [12:0] RECIP_25 = 13'd5243;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE_W,
        S_BASE,
        S_OTHER_W,
        S_OTHER,
        S_DIFF,
        S_ADD,
        S_RANGE,
        S_YEAR_W,
        S_YEAR_LO,
        S_YEAR_HI_W,
        S_YEAR_HI,
        S_MONTH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [DN_W-1:0] dby;
        logic            leap;
    } t_year_info;

    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                        d = leap ? 5'd29 : 5'd28;
            default:                                     d = 5'd0;
        endcase
        return d;
    endfunction

    // days in a common year before the first of month m
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

[src/gda_year_unit.sv]
// Two-stage year unit: days before January 1 of a year, and its leap flag.
module gda_year_unit (
    input  logic                       i_clk,
    input  logic [gda_pkg::YEAR_W-1:0] i_year,
    output gda_pkg::t_year_info        o_info
);

    logic [gda_pkg::YEAR_W-1:0] r_year;
    logic [10:0]                r_q;
    logic [gda_pkg::DN_W-1:0]   r_p365;
    gda_pkg::t_year_info        r_info;

    logic [gda_pkg::YEAR_W-1:0] p;
    logic [14:0]                a_in;
    logic [27:0]                prod;
    logic [14:0]                a;
    logic                       m4;
    logic                       m100;
    logic                       m400;
    gda_pkg::t_year_info        n_info;

    always_comb begin
        p    = i_year - 17'd1;
        a_in = i_year[16:2];
        prod = 28'(a_in) * 28'(gda_pkg::RECIP_25);
    end

    // q = floor(year/100); the missing terms of (year-1) follow from the hit flags
    always_comb begin
        a    = r_year[16:2];
        m4   = (r_year[1:0] == 2'd0);
        m100 = m4 && ({1'b0, a} == 16'(r_q) * 16'd25);
        m400 = m100 && (r_q[1:0] == 2'd0);
        n_info.leap = m4 && (!m100 || m400);
        n_info.dby  = r_p365 + 25'(a) - 25'(m4) - 25'(r_q) + 25'(m100)
                    + 25'(r_q[10:2]) - 25'(m400);
    end

    always_ff @(posedge i_clk) begin
        r_year <= i_year;
        r_q    <= prod[27:17];
        r_p365 <= 25'(p) * 25'd365;
        r_info <= n_info;
    end

    assign o_info = r_info;

endmodule

[src/gregorian_date_arithmetic.sv]
// A difference checks both dates and subtracts; an add checks the base date, adds the offset,
// checks the range, searches the year and walks the months. A bad date, or an add that leaves
// the calendar, ends the request early. Each year lookup goes through the two-stage year unit,
// which the year search reuses; a year estimate that misses by one costs one more lookup, and
// the month walk then takes one month per cycle. One request at a time: the next is taken once
// the result is registered. Reset (synchronous, active low) returns to idle and drops the result.
module gregorian_date_arithmetic #(
    parameter int MAX_YEAR = 9999
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [0:0]         i_req_type,
    input  logic [13:0]        i_base_year,
    input  logic [3:0]         i_base_month,
    input  logic [4:0]         i_base_day,
    input  logic signed [22:0] i_day_offset,
    input  logic [13:0]        i_other_year,
    input  logic [3:0]         i_other_month,
    input  logic [4:0]         i_other_day,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [13:0]        o_out_year,
    output logic [3:0]         o_out_month,
    output logic [4:0]         o_out_day,
    output logic signed [22:0] o_day_difference,
    output logic [1:0]         o_status
);

    // Day count of January 1 after MAX_YEAR: first day number out of range.
    localparam int DAYS_END = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
    // Year estimate: years ~= days * 400 / 146097, as a 2^-32 scaled reciprocal.
    localparam logic [23:0] EST_K = 24'((64'd400 << 32) / 64'd146097);

    gda_pkg::t_state r_state, n_state;
    logic            r_wait, n_wait;

    // Request fields, held for the whole request
    logic [0:0]  r_req_type;
    logic [13:0] r_base_year;
    logic [3:0]  r_base_month;
    logic [4:0]  r_base_day;
    logic [22:0] r_off;
    logic [13:0] r_other_year;
    logic [3:0]  r_other_month;
    logic [4:0]  r_other_day;

    // Work registers
    logic [16:0]        r_yu_year, n_yu_year;
    logic [24:0]        r_dnb, n_dnb;
    logic [24:0]        r_dno, n_dno;
    logic signed [25:0] r_n, n_n;
    logic [16:0]        r_y, n_y;
    logic [24:0]        r_dby_y, n_dby_y;
    logic               r_leap_y, n_leap_y;
    logic [8:0]         r_rem, n_rem;
    logic [3:0]         r_m, n_m;

    // Finished result, waiting for the output register
    logic [13:0] r_res_year, n_res_year;
    logic [3:0]  r_res_month, n_res_month;
    logic [4:0]  r_res_day, n_res_day;
    logic [22:0] r_res_diff, n_res_diff;
    logic [1:0]  r_res_status, n_res_status;

    // Output register
    logic        r_o_valid, n_o_valid;
    logic [13:0] r_o_year, n_o_year;
    logic [3:0]  r_o_month, n_o_month;
    logic [4:0]  r_o_day, n_o_day;
    logic [22:0] r_o_diff, n_o_diff;
    logic [1:0]  r_o_status, n_o_status;

    gda_pkg::t_year_info yu;

    // Date check and day number, shared by the base and the other date
    logic [13:0]        chk_year;
    logic [3:0]         chk_month;
    logic [4:0]         chk_day;
    logic [4:0]         chk_dim;
    logic               chk_ok;
    logic [24:0]        chk_dn;
    logic signed [25:0] diff;
    logic               out_low;
    logic               out_high;
    logic [48:0]        est_prod;
    logic [4:0]         walk_dim;
    logic               out_free;
    logic               do_accept;

    gda_year_unit u_year (
        .i_clk  (i_clk),
        .i_year (r_yu_year),
        .o_info (yu)
    );

    assign do_accept = i_valid && (r_state == gda_pkg::S_IDLE);
    assign out_free  = !r_o_valid || !i_stall;

    always_comb begin
        if (r_state == gda_pkg::S_OTHER) begin
            chk_year  = r_other_year;
            chk_month = r_other_month;
            chk_day   = r_other_day;
        end else begin
            chk_year  = r_base_year;
            chk_month = r_base_month;
            chk_day   = r_base_day;
        end
        chk_dim = gda_pkg::days_in_month(chk_month, yu.leap);
        chk_ok  = (chk_year != 14'd0) && ({3'b0, chk_year} <= 17'(MAX_YEAR))
               && (chk_month inside {[4'd1:4'd12]})
               && (chk_day != 5'd0) && (chk_day <= chk_dim);
        chk_dn  = yu.dby + 25'(gda_pkg::cum_days(chk_month))
                + 25'(yu.leap && (chk_month > 4'd2)) + 25'(chk_day) - 25'd1;
    end

    always_comb begin
        diff     = $signed({1'b0, r_dnb}) - $signed({1'b0, r_dno});
        out_low  = r_n[25];
        out_high = (r_n >= 26'(DAYS_END));
        est_prod = 49'(r_n[24:0]) * 49'(EST_K);
        walk_dim = gda_pkg::days_in_month(r_m, r_leap_y);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gda_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = gda_pkg::S_BASE_W;
                end
            end
            gda_pkg::S_BASE_W: begin
                if (r_wait) begin
                    n_state = gda_pkg::S_BASE;
                end
            end
            gda_pkg::S_BASE: begin
                if (!chk_ok) begin
                    n_state = gda_pkg::S_DONE;
                end else if (r_req_type == gda_pkg::REQ_DIFF) begin
                    n_state = gda_pkg::S_OTHER_W;
                end else begin
                    n_state = gda_pkg::S_ADD;
                end
            end
            gda_pkg::S_OTHER_W: begin
                if (r_wait) begin
                    n_state = gda_pkg::S_OTHER;
                end
            end
            gda_pkg::S_OTHER: begin
                n_state = chk_ok ? gda_pkg::S_DIFF : gda_pkg::S_DONE;
            end
            gda_pkg::S_DIFF:  n_state = gda_pkg::S_DONE;
            gda_pkg::S_ADD:   n_state = gda_pkg::S_RANGE;
            gda_pkg::S_RANGE: begin
                n_state = (out_low || out_high) ? gda_pkg::S_DONE : gda_pkg::S_YEAR_W;
            end
            gda_pkg::S_YEAR_W: begin
                if (r_wait) begin
                    n_state = gda_pkg::S_YEAR_LO;
                end
            end
            gda_pkg::S_YEAR_LO: begin
                n_state = (yu.dby > r_n[24:0]) ? gda_pkg::S_YEAR_W : gda_pkg::S_YEAR_HI_W;
            end
            gda_pkg::S_YEAR_HI_W: begin
                if (r_wait) begin
                    n_state = gda_pkg::S_YEAR_HI;
                end
            end
            gda_pkg::S_YEAR_HI: begin
                n_state = (yu.dby <= r_n[24:0]) ? gda_pkg::S_YEAR_HI_W : gda_pkg::S_MONTH;
            end
            gda_pkg::S_MONTH: begin
                if (!((r_m < 4'd12) && ({4'b0, walk_dim} <= r_rem))) begin
                    n_state = gda_pkg::S_DONE;
                end
            end
            gda_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = gda_pkg::S_IDLE;
                end
            end
            default: n_state = gda_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_wait       = 1'b0;
        n_yu_year    = r_yu_year;
        n_dnb        = r_dnb;
        n_dno        = r_dno;
        n_n          = r_n;
        n_y          = r_y;
        n_dby_y      = r_dby_y;
        n_leap_y     = r_leap_y;
        n_rem        = r_rem;
        n_m          = r_m;
        n_res_year   = r_res_year;
        n_res_month  = r_res_month;
        n_res_day    = r_res_day;
        n_res_diff   = r_res_diff;
        n_res_status = r_res_status;
        n_o_valid    = r_o_valid && i_stall;
        n_o_year     = r_o_year;
        n_o_month    = r_o_month;
        n_o_day      = r_o_day;
        n_o_diff     = r_o_diff;
        n_o_status   = r_o_status;

        case (r_state)
            gda_pkg::S_IDLE: begin
                n_yu_year = {3'b0, i_base_year};
            end
            gda_pkg::S_BASE_W, gda_pkg::S_OTHER_W, gda_pkg::S_YEAR_W,
            gda_pkg::S_YEAR_HI_W: begin
                n_wait = !r_wait;
            end
            gda_pkg::S_BASE: begin
                n_dnb     = chk_dn;
                n_yu_year = {3'b0, r_other_year};
                if (!chk_ok) begin
                    n_res_year   = 14'd0;
                    n_res_month  = 4'd0;
                    n_res_day    = 5'd0;
                    n_res_diff   = 23'd0;
                    n_res_status = gda_pkg::ST_BAD_DATE;
                end
            end
            gda_pkg::S_OTHER: begin
                n_dno = chk_dn;
                if (!chk_ok) begin
                    n_res_year   = 14'd0;
                    n_res_month  = 4'd0;
                    n_res_day    = 5'd0;
                    n_res_diff   = 23'd0;
                    n_res_status = gda_pkg::ST_BAD_DATE;
                end
            end
            gda_pkg::S_DIFF: begin
                // saturate to the 23-bit result field
                if (diff > gda_pkg::DIFF_MAX) begin
                    n_res_diff = gda_pkg::DIFF_MAX[22:0];
                end else if (diff < gda_pkg::DIFF_MIN) begin
                    n_res_diff = gda_pkg::DIFF_MIN[22:0];
                end else begin
                    n_res_diff = diff[22:0];
                end
                n_res_year   = 14'd0;
                n_res_month  = 4'd0;
                n_res_day    = 5'd0;
                n_res_status = gda_pkg::ST_OK;
            end
            gda_pkg::S_ADD: begin
                n_n = $signed({1'b0, r_dnb}) + $signed({{3{r_off[22]}}, r_off});
            end
            gda_pkg::S_RANGE: begin
                n_y       = est_prod[48:32] + 17'd1;
                n_yu_year = est_prod[48:32] + 17'd1;
                if (out_low || out_high) begin
                    n_res_year   = 14'd0;
                    n_res_month  = 4'd0;
                    n_res_day    = 5'd0;
                    n_res_diff   = 23'd0;
                    n_res_status = gda_pkg::ST_RANGE;
                end
            end
            gda_pkg::S_YEAR_LO: begin
                // step back while the year starts after the day; else probe the next year
                if (yu.dby > r_n[24:0]) begin
                    n_y       = r_y - 17'd1;
                    n_yu_year = r_y - 17'd1;
                end else begin
                    n_dby_y   = yu.dby;
                    n_leap_y  = yu.leap;
                    n_yu_year = r_y + 17'd1;
                end
            end
            gda_pkg::S_YEAR_HI: begin
                if (yu.dby <= r_n[24:0]) begin
                    n_y       = r_y + 17'd1;
                    n_dby_y   = yu.dby;
                    n_leap_y  = yu.leap;
                    n_yu_year = r_y + 17'd2;
                end else begin
                    n_rem = 9'(r_n[24:0] - r_dby_y);
                    n_m   = 4'd1;
                end
            end
            gda_pkg::S_MONTH: begin
                if ((r_m < 4'd12) && ({4'b0, walk_dim} <= r_rem)) begin
                    n_rem = r_rem - {4'b0, walk_dim};
                    n_m   = r_m + 4'd1;
                end else begin
                    n_res_year   = r_y[13:0];
                    n_res_month  = r_m;
                    n_res_day    = 5'(r_rem + 9'd1);
                    n_res_diff   = 23'd0;
                    n_res_status = gda_pkg::ST_OK;
                end
            end
            gda_pkg::S_DONE: begin
                // hand the result over once the output register is free
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_year   = r_res_year;
                    n_o_month  = r_res_month;
                    n_o_day    = r_res_day;
                    n_o_diff   = r_res_diff;
                    n_o_status = r_res_status;
                end
            end
            default: begin
                n_wait = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gda_pkg::S_IDLE;
            r_wait    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wait    <= n_wait;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (do_accept) begin
            r_req_type    <= i_req_type;
            r_base_year   <= i_base_year;
            r_base_month  <= i_base_month;
            r_base_day    <= i_base_day;
            r_off         <= i_day_offset;
            r_other_year  <= i_other_year;
            r_other_month <= i_other_month;
            r_other_day   <= i_other_day;
        end
        r_yu_year    <= n_yu_year;
        r_dnb        <= n_dnb;
        r_dno        <= n_dno;
        r_n          <= n_n;
        r_y          <= n_y;
        r_dby_y      <= n_dby_y;
        r_leap_y     <= n_leap_y;
        r_rem        <= n_rem;
        r_m          <= n_m;
        r_res_year   <= n_res_year;
        r_res_month  <= n_res_month;
        r_res_day    <= n_res_day;
        r_res_diff   <= n_res_diff;
        r_res_status <= n_res_status;
        r_o_year     <= n_o_year;
        r_o_month    <= n_o_month;
        r_o_day      <= n_o_day;
        r_o_diff     <= n_o_diff;
        r_o_status   <= n_o_status;
    end

    assign o_stall          = (r_state != gda_pkg::S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_out_year       = r_o_year;
    assign o_out_month      = r_o_month;
    assign o_out_day        = r_o_day;
    assign o_day_difference = r_o_diff;
    assign o_status         = r_o_status;

endmodule

[dv/gregorian_date_arithmetic_test.sv]
module gregorian_date_arithmetic_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_YEAR = 9999;
    // random requests spread over the four idling phases
    localparam int RANDOM_REQUESTS = 1640;

    // One request as it sits on the input ports
    typedef struct packed {
        logic [0:0]         req_type;
        logic [13:0]        base_year;
        logic [3:0]         base_month;
        logic [4:0]         base_day;
        logic signed [22:0] day_offset;
        logic [13:0]        other_year;
        logic [3:0]         other_month;
        logic [4:0]         other_day;
    } t_date_req;

    // One result as it leaves the block
    typedef struct packed {
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [22:0] day_difference;
        logic [1:0]         status;
    } t_date_result;

    // Calendar predictor plus the queue of results still owed by the block
    class date_result_board;
        t_date_result pending_date_results[$];
        int errors;
        int n_checked;
        int n_shift;
        int n_count;
        int n_bad;
        int n_range;

        function bit leap_year(longint y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function longint month_length(longint y, longint m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        // days from 0001-01-01 to January 1 of year y
        function longint days_to_year(longint y);
            longint p;
            p = y - 1;
            return p * 365 + p / 4 - p / 100 + p / 400;
        endfunction

        function bit valid_date(longint y, longint m, longint d);
            if (y < 1 || y > MAX_YEAR || m < 1 || m > 12)
                return 1'b0;
            return d >= 1 && d <= month_length(y, m);
        endfunction

        function longint day_index(longint y, longint m, longint d);
            longint n;
            n = days_to_year(y);
            for (longint k = 1; k < m; k++)
                n += month_length(y, k);
            return n + d - 1;
        endfunction

        function t_date_result compute_date_result(t_date_req r);
            t_date_result e;
            longint n;
            longint y;
            longint m;
            e = '0;
            if (!valid_date(r.base_year, r.base_month, r.base_day)) begin
                e.status = gda_pkg::ST_BAD_DATE;
                return e;
            end
            if (r.req_type == gda_pkg::REQ_ADD) begin
                n = day_index(r.base_year, r.base_month, r.base_day)
                    + longint'($signed(r.day_offset));
                if (n < 0 || n >= days_to_year(MAX_YEAR + 1)) begin
                    e.status = gda_pkg::ST_RANGE;
                    return e;
                end
                y = n * 400 / 146097 + 1;
                while (y > 1 && days_to_year(y) > n)
                    y--;
                while (days_to_year(y + 1) <= n)
                    y++;
                n -= days_to_year(y);
                m = 1;
                while (m < 12 && n >= month_length(y, m)) begin
                    n -= month_length(y, m);
                    m++;
                end
                e.year  = 14'(y);
                e.month = 4'(m);
                e.day   = 5'(n + 1);
                e.status = gda_pkg::ST_OK;
            end else begin
                if (!valid_date(r.other_year, r.other_month, r.other_day)) begin
                    e.status = gda_pkg::ST_BAD_DATE;
                    return e;
                end
                n = day_index(r.base_year, r.base_month, r.base_day)
                    - day_index(r.other_year, r.other_month, r.other_day);
                if (n > 4194303)
                    n = 4194303;
                if (n < -4194304)
                    n = -4194304;
                e.day_difference = 23'(n);
                e.status = gda_pkg::ST_OK;
            end
            return e;
        endfunction

        function void note_request(t_date_req r);
            t_date_result e;
            e = compute_date_result(r);
            pending_date_results.push_back(e);
            if (e.status == gda_pkg::ST_BAD_DATE)
                n_bad++;
            else if (e.status == gda_pkg::ST_RANGE)
                n_range++;
            else if (r.req_type == gda_pkg::REQ_ADD)
                n_shift++;
            else
                n_count++;
        endfunction

        function void check_result(t_date_result got);
            t_date_result e;
            n_checked++;
            if (pending_date_results.size() == 0) begin
                $error("result with nothing pending: year %0d month %0d day %0d diff %0d st %0d",
                       got.year, got.month, got.day, $signed(got.day_difference), got.status);
                errors++;
                return;
            end
            e = pending_date_results.pop_front();
            if (got.year !== e.year) begin
                $error("out_year: expected %0d actual %0d", e.year, got.year);
                errors++;
            end
            if (got.month !== e.month) begin
                $error("out_month: expected %0d actual %0d", e.month, got.month);
                errors++;
            end
            if (got.day !== e.day) begin
                $error("out_day: expected %0d actual %0d", e.day, got.day);
                errors++;
            end
            if (got.day_difference !== e.day_difference) begin
                $error("day_difference: expected %0d actual %0d",
                       $signed(e.day_difference), $signed(got.day_difference));
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d actual %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [0:0]         i_req_type;
    logic [13:0]        i_base_year;
    logic [3:0]         i_base_month;
    logic [4:0]         i_base_day;
    logic signed [22:0] i_day_offset;
    logic [13:0]        i_other_year;
    logic [3:0]         i_other_month;
    logic [4:0]         i_other_day;
    logic               o_valid;
    logic               i_stall;
    logic [13:0]        o_out_year;
    logic [3:0]         o_out_month;
    logic [4:0]         o_out_day;
    logic signed [22:0] o_day_difference;
    logic [1:0]         o_status;

    // percent chance per cycle that the sender idles or the receiver stalls
    int src_idle_pct;
    int sink_stall_pct;

    date_result_board board;

    gregorian_date_arithmetic #(
        .MAX_YEAR(MAX_YEAR)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_base_year     (i_base_year),
        .i_base_month    (i_base_month),
        .i_base_day      (i_base_day),
        .i_day_offset    (i_day_offset),
        .i_other_year    (i_other_year),
        .i_other_month   (i_other_month),
        .i_other_day     (i_other_day),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_year      (o_out_year),
        .o_out_month     (o_out_month),
        .o_out_day       (o_out_day),
        .o_day_difference(o_day_difference),
        .o_status        (o_status)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Randomize receiver back-pressure on the falling edge so the block sees it
    // settled at the next rising edge.
    always @(negedge i_clk) begin
        i_stall = ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Sample every delivered result at the rising edge and hand it to the board.
    always @(posedge i_clk) begin
        t_date_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.year           = o_out_year;
            got.month          = o_out_month;
            got.day            = o_out_day;
            got.day_difference = o_day_difference;
            got.status         = o_status;
            board.check_result(got);
        end
    end

    // Present one request: idle at random first, then hold the payload until
    // the block takes it.
    task automatic drive_request(t_date_req r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_req_type    = r.req_type;
        i_base_year   = r.base_year;
        i_base_month  = r.base_month;
        i_base_day    = r.base_day;
        i_day_offset  = r.day_offset;
        i_other_year  = r.other_year;
        i_other_month = r.other_month;
        i_other_day   = r.other_day;
        i_valid       = 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.note_request(r);
    endtask

    task automatic send_date_op(logic [0:0] kind, int by, int bm, int bd, int off,
                                int oy, int om, int od);
        t_date_req r;
        r.req_type    = kind;
        r.base_year   = 14'(by);
        r.base_month  = 4'(bm);
        r.base_day    = 5'(bd);
        r.day_offset  = 23'(off);
        r.other_year  = 14'(oy);
        r.other_month = 4'(om);
        r.other_day   = 5'(od);
        drive_request(r);
    endtask

    // Drop valid and wait until the block has returned everything it owes.
    task automatic drain_requests();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (board.pending_date_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Pick a valid date, leaning on the calendar corners: the first and last
    // years, century and leap years, and month ends.
    task automatic pick_date(output logic [13:0] y, output logic [3:0] m,
                             output logic [4:0] d);
        int sel;
        int yy;
        int len;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       yy = $urandom_range(1, 4);
            1:       yy = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
            2:       yy = 100 * $urandom_range(1, MAX_YEAR / 100);
            3:       yy = 4 * $urandom_range(1, MAX_YEAR / 4);
            default: yy = $urandom_range(1, MAX_YEAR);
        endcase
        y = 14'(yy);
        m = 4'($urandom_range(1, 12));
        len = int'(board.month_length(yy, m));
        if ($urandom_range(0, 3) == 0)
            d = 5'(len);
        else
            d = 5'($urandom_range(1, len));
    endtask

    // Mostly well-formed requests with random content, plus raw noise dates.
    task automatic draw_request(output t_date_req r);
        int sel;
        int mag;
        int len;
        r.req_type = $urandom_range(0, 1) ? gda_pkg::REQ_DIFF : gda_pkg::REQ_ADD;
        if ($urandom_range(0, 99) < 12) begin
            r.base_year  = 14'($urandom);
            r.base_month = 4'($urandom);
            r.base_day   = 5'($urandom);
        end else begin
            pick_date(r.base_year, r.base_month, r.base_day);
        end

        sel = $urandom_range(0, 5);
        case (sel)
            0:       mag = -1;
            1:       mag = 60;
            2:       mag = 1500;
            3:       mag = 400000;
            default: mag = -2;
        endcase
        if (mag == -2)
            r.day_offset = 23'($urandom);
        else if (mag == -1)
            r.day_offset = 23'($urandom_range(0, 2) - 1);
        else
            r.day_offset = 23'(int'($urandom_range(0, 2 * mag)) - mag);

        sel = $urandom_range(0, 9);
        if (r.req_type == gda_pkg::REQ_ADD || sel == 0) begin
            // ignored in add mode, so any bits will do; in diff mode these are raw noise dates
            r.other_year  = 14'($urandom);
            r.other_month = 4'($urandom);
            r.other_day   = 5'($urandom);
        end else if (sel <= 3 && r.base_month >= 1 && r.base_month <= 12) begin
            // same month as the base date
            r.other_year  = r.base_year;
            r.other_month = r.base_month;
            len = int'(board.month_length(r.base_year, r.base_month));
            r.other_day   = 5'($urandom_range(1, (len == 0) ? 31 : len));
        end else if (sel == 4) begin
            r.other_year  = r.base_year;
            r.other_month = r.base_month;
            r.other_day   = r.base_day;
        end else begin
            pick_date(r.other_year, r.other_month, r.other_day);
        end
    endtask

    initial begin
        t_date_req r;
        int phase;
        board = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_req_type    = gda_pkg::REQ_ADD;
        i_base_year   = '0;
        i_base_month  = '0;
        i_base_day    = '0;
        i_day_offset  = '0;
        i_other_year  = '0;
        i_other_month = '0;
        i_other_day   = '0;

        // hold reset, then release it on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners, no idling on either side.
        // leap day rules: divisible by 4, century exception, 400-year exception
        send_date_op(gda_pkg::REQ_ADD, 2024, 2, 28, 1, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 2023, 2, 28, 1, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 1900, 2, 28, 1, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 2000, 2, 28, 1, 0, 0, 0);
        // subtract across a leap day and a year boundary, and a zero offset
        send_date_op(gda_pkg::REQ_ADD, 2024, 3, 1, -1, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 2025, 1, 1, -1, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 2024, 12, 31, 0, 16383, 15, 31);
        // step off either end of the calendar
        send_date_op(gda_pkg::REQ_ADD, 1, 1, 1, -1, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, MAX_YEAR, 12, 31, 1, 0, 0, 0);
        // offset extremes
        send_date_op(gda_pkg::REQ_ADD, 1, 1, 1, 4194303, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, MAX_YEAR, 12, 31, -4194304, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, MAX_YEAR, 12, 31, -3652058, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 1, 1, 1, 3652058, 0, 0, 0);
        // invalid base dates
        send_date_op(gda_pkg::REQ_ADD, 0, 1, 1, 5, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 16383, 15, 31, 5, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 2020, 0, 10, 5, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 2020, 4, 31, 5, 0, 0, 0);
        send_date_op(gda_pkg::REQ_ADD, 1900, 2, 29, 5, 0, 0, 0);
        send_date_op(gda_pkg::REQ_DIFF, 2020, 5, 0, 0, 2020, 5, 1);
        // differences: same month, across a leap day, full span both ways
        send_date_op(gda_pkg::REQ_DIFF, 2024, 5, 20, 0, 2024, 5, 3);
        send_date_op(gda_pkg::REQ_DIFF, 2024, 3, 1, 0, 2024, 2, 28);
        send_date_op(gda_pkg::REQ_DIFF, MAX_YEAR, 12, 31, 0, 1, 1, 1);
        send_date_op(gda_pkg::REQ_DIFF, 1, 1, 1, 0, MAX_YEAR, 12, 31);
        // invalid second date
        send_date_op(gda_pkg::REQ_DIFF, 2024, 5, 20, 0, 2024, 13, 1);
        send_date_op(gda_pkg::REQ_DIFF, 2024, 5, 20, 0, 2023, 2, 29);

        // Random traffic in four idling phases. Drain between phases so the
        // sender sits idle until every owed result has come back.
        for (phase = 0; phase < 4; phase++) begin
            drain_requests();
            case (phase)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 51;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 51;
                end
                default: begin
                    src_idle_pct   = 33;
                    sink_stall_pct = 33;
                end
            endcase
            repeat (RANDOM_REQUESTS / 4) begin
                draw_request(r);
                drive_request(r);
            end
        end

        // Drain, then give the block time to show any stray result.
        drain_requests();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (100) @(posedge i_clk);

        $display("covered %0d results: %0d date shifts, %0d day counts,",
                 board.n_checked, board.n_shift, board.n_count);
        $display("  %0d rejected dates, %0d shifts past the calendar ends, %0d mismatches",
                 board.n_bad, board.n_range, board.errors);
        if (board.errors == 0 && board.pending_date_results.size() == 0) begin
            $display("gregorian_date_arithmetic_test: clean");
        end else begin
            $display("gregorian_date_arithmetic_test: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("gregorian_date_arithmetic_test: errors");
        $finish;
    end

endmodule
